>>> rtl/bst_pkg.sv
// ============================================================================
// bst_pkg - shared types and constants for the breakpoint shadow table
// Opcodes, result kinds, controller states and the control bundles that run
// between the controller and the datapath.
// ============================================================================
package bst_pkg;

    localparam int MAX_ENTRIES = 32;
    localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
    localparam int IDX_W       = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;

    localparam int ADDR_W      = 32;
    localparam int BYTE_W      = 8;
    localparam int IN_DATA_W   = 40;
    localparam int OUT_DATA_W  = 80;

    localparam logic [BYTE_W-1:0] TRAP_BYTE = 8'hCC;

    typedef enum logic [2:0] {
        OP_INSERT   = 3'd0,
        OP_REMOVE   = 3'd1,
        OP_TRAP     = 3'd2,
        OP_CONTINUE = 3'd3,
        OP_STEP     = 3'd4,
        OP_TRACE    = 3'd5
    } op_t;

    typedef enum logic [2:0] {
        RES_INS_OK,
        RES_BLANK,
        RES_REM_HIT,
        RES_TRAP_HIT,
        RES_TRAP_MISS,
        RES_ARM,
        RES_FLAG,
        RES_SWALLOW
    } res_kind_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_SCAN,
        ST_MOVE,
        ST_ARM,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic      load;
        logic      idx_clr;
        logic      idx_inc;
        logic      idx_tail;
        logic      ins_write;
        logic      move_write;
        logic      count_dec;
        logic      capture;
        logic      step_set;
        logic      step_clr;
        logic      emit;
        res_kind_t res_kind;
    } cmd_t;

    typedef struct packed {
        op_t  op;
        logic count_zero;
        logic full;
        logic stepping;
        logic match;
        logic at_tail;
        logic out_free;
    } status_t;

endpackage

>>> rtl/bst_dp.sv
// ============================================================================
// bst_dp - breakpoint shadow table datapath
// Entry memory with a registered read port, entry count, scan index, captured
// item, hit capture and the result output register.
// ============================================================================
module bst_dp (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic [bst_pkg::IN_DATA_W-1:0]       s_tdata,
    input  logic [2:0]                          s_tuser,
    input  bst_pkg::cmd_t                       cmd,
    output bst_pkg::status_t                    status,
    input  logic                                m_tready,
    output logic                                m_tvalid,
    output logic [bst_pkg::OUT_DATA_W-1:0]      m_tdata,
    output logic                                m_tlast
);

    // entry memory: saved byte above address
    logic [bst_pkg::ADDR_W+bst_pkg::BYTE_W-1:0] mem [bst_pkg::MAX_ENTRIES];
    logic [bst_pkg::ADDR_W+bst_pkg::BYTE_W-1:0] rd_reg;

    logic [bst_pkg::CNT_W-1:0]  count_reg;
    logic                       stepping_reg;
    logic [bst_pkg::IDX_W-1:0]  idx_reg;
    logic [bst_pkg::IDX_W-1:0]  idx_next;
    logic [bst_pkg::IDX_W-1:0]  hit_idx_reg;
    logic [bst_pkg::BYTE_W-1:0] hit_byte_reg;

    bst_pkg::op_t               op_reg;
    logic [bst_pkg::ADDR_W-1:0] addr_reg;
    logic [bst_pkg::ADDR_W-1:0] key_reg;
    logic [bst_pkg::BYTE_W-1:0] byte_reg;

    logic [bst_pkg::ADDR_W-1:0] rd_addr;
    logic [bst_pkg::BYTE_W-1:0] rd_byte;
    logic [bst_pkg::CNT_W-1:0]  tail;

    logic                       out_valid_reg;
    logic [bst_pkg::OUT_DATA_W-1:0] out_data_reg;
    logic                       out_last_reg;

    logic                       r_wv;
    logic [bst_pkg::ADDR_W-1:0] r_wa;
    logic [bst_pkg::BYTE_W-1:0] r_wd;
    logic                       r_hit;
    logic [bst_pkg::ADDR_W-1:0] r_pc;
    logic                       r_dbg;
    logic                       r_tf;
    logic                       r_last;

    bst_pkg::op_t               in_op;
    logic                       out_free;

    assign rd_addr = rd_reg[bst_pkg::ADDR_W-1:0];
    assign rd_byte = rd_reg[bst_pkg::ADDR_W+bst_pkg::BYTE_W-1:bst_pkg::ADDR_W];
    assign tail    = count_reg - bst_pkg::CNT_W'(1);
    assign in_op   = bst_pkg::op_t'(s_tuser);
    assign out_free = !out_valid_reg || m_tready;

    always_comb
    begin
        idx_next = idx_reg;
        if (cmd.idx_clr)
        begin
            idx_next = '0;
        end
        else if (cmd.idx_inc)
        begin
            idx_next = idx_reg + bst_pkg::IDX_W'(1);
        end
        else if (cmd.idx_tail)
        begin
            idx_next = tail[bst_pkg::IDX_W-1:0];
        end
    end

    // memory: one write, one registered read at the next scan index
    always_ff @(posedge clk)
    begin
        if (cmd.ins_write)
        begin
            mem[count_reg[bst_pkg::IDX_W-1:0]] <= {byte_reg, addr_reg};
        end
        else if (cmd.move_write)
        begin
            mem[hit_idx_reg] <= rd_reg;
        end
        rd_reg <= mem[idx_next];
    end

    // item and hit capture
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg   <= in_op;
            addr_reg <= s_tdata[bst_pkg::ADDR_W-1:0];
            byte_reg <= s_tdata[bst_pkg::ADDR_W+bst_pkg::BYTE_W-1:bst_pkg::ADDR_W];
            // remove searches the address itself, trap and trace search pc-1
            key_reg  <= (in_op == bst_pkg::OP_REMOVE) ? s_tdata[bst_pkg::ADDR_W-1:0]
                        : s_tdata[bst_pkg::ADDR_W-1:0] - bst_pkg::ADDR_W'(1);
        end
        if (cmd.capture)
        begin
            hit_idx_reg  <= idx_reg;
            hit_byte_reg <= rd_byte;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            stepping_reg <= 1'b0;
            idx_reg      <= '0;
        end
        else
        begin
            idx_reg <= idx_next;
            if (cmd.ins_write)
            begin
                count_reg <= count_reg + bst_pkg::CNT_W'(1);
            end
            else if (cmd.count_dec)
            begin
                count_reg <= tail;
            end
            if (cmd.step_set)
            begin
                stepping_reg <= 1'b1;
            end
            else if (cmd.step_clr)
            begin
                stepping_reg <= 1'b0;
            end
        end
    end

    // result fields by kind
    always_comb
    begin
        r_wv   = 1'b0;
        r_wa   = '0;
        r_wd   = '0;
        r_hit  = 1'b0;
        r_pc   = '0;
        r_dbg  = 1'b0;
        r_tf   = 1'b0;
        r_last = 1'b1;
        unique case (cmd.res_kind)
            bst_pkg::RES_INS_OK:
            begin
                r_wv  = 1'b1;
                r_wa  = addr_reg;
                r_wd  = bst_pkg::TRAP_BYTE;
                r_hit = 1'b1;
            end
            bst_pkg::RES_REM_HIT:
            begin
                r_wv  = 1'b1;
                r_wa  = addr_reg;
                r_wd  = hit_byte_reg;
                r_hit = 1'b1;
            end
            bst_pkg::RES_TRAP_HIT:
            begin
                r_wv  = 1'b1;
                r_wa  = key_reg;
                r_wd  = hit_byte_reg;
                r_hit = 1'b1;
                r_pc  = key_reg;
                r_dbg = 1'b1;
            end
            bst_pkg::RES_TRAP_MISS:
            begin
                r_pc  = addr_reg;
                r_dbg = 1'b1;
            end
            bst_pkg::RES_ARM:
            begin
                r_wv   = 1'b1;
                r_wa   = rd_addr;
                r_wd   = bst_pkg::TRAP_BYTE;
                r_tf   = 1'b1;
                r_last = status.at_tail;
            end
            bst_pkg::RES_FLAG:
            begin
                r_tf = 1'b1;
            end
            bst_pkg::RES_SWALLOW:
            begin
                r_pc = addr_reg;
            end
            default:
            begin
                r_wv = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit && out_free)
        begin
            out_data_reg <= {4'b0, r_tf, r_dbg, r_pc, r_hit, r_wd, r_wa, r_wv};
            out_last_reg <= r_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit && out_free)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

    assign status.op         = op_reg;
    assign status.count_zero = (count_reg == '0);
    assign status.full       = (count_reg == bst_pkg::CNT_W'(bst_pkg::MAX_ENTRIES));
    assign status.stepping   = stepping_reg;
    assign status.match      = (rd_addr == key_reg);
    assign status.at_tail    = (bst_pkg::CNT_W'(idx_reg) == tail);
    assign status.out_free   = out_free;

`ifndef SYNTHESIS
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= bst_pkg::CNT_W'(bst_pkg::MAX_ENTRIES))
        else $error("entry count beyond table depth");

    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> out_free)
        else $error("result issued while output register is held");

    a_insert_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.ins_write |-> !status.full)
        else $error("insert into a full table");

    a_remove_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.count_dec |-> !status.count_zero && $past(cmd.capture))
        else $error("remove without a matched entry");
`endif

endmodule

>>> rtl/bst_ctrl.sv
// ============================================================================
// bst_ctrl - breakpoint shadow table controller
// Sequences dispatch, table scan, hole fill and re-arm walk for each item.
// ============================================================================
module bst_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  bst_pkg::status_t  status,
    output bst_pkg::cmd_t     cmd
);

    bst_pkg::state_t    state_reg;
    bst_pkg::state_t    state_next;
    bst_pkg::res_kind_t kind_reg;
    bst_pkg::res_kind_t kind_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= bst_pkg::ST_IDLE;
            kind_reg  <= bst_pkg::RES_BLANK;
        end
        else
        begin
            state_reg <= state_next;
            kind_reg  <= kind_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        kind_next    = kind_reg;
        cmd          = '0;
        cmd.res_kind = kind_reg;
        s_tready     = 1'b0;
        unique case (state_reg)
            bst_pkg::ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.load    = 1'b1;
                    cmd.idx_clr = 1'b1;
                    state_next  = bst_pkg::ST_DISPATCH;
                end
            end
            bst_pkg::ST_DISPATCH:
            begin
                state_next = bst_pkg::ST_EMIT;
                unique case (status.op)
                    bst_pkg::OP_INSERT:
                    begin
                        if (status.full)
                        begin
                            kind_next = bst_pkg::RES_BLANK;
                        end
                        else
                        begin
                            cmd.ins_write = 1'b1;
                            kind_next     = bst_pkg::RES_INS_OK;
                        end
                    end
                    bst_pkg::OP_REMOVE:
                    begin
                        kind_next = bst_pkg::RES_BLANK;
                        if (!status.count_zero)
                        begin
                            state_next = bst_pkg::ST_SCAN;
                        end
                    end
                    bst_pkg::OP_TRAP:
                    begin
                        kind_next = bst_pkg::RES_TRAP_MISS;
                        if (!status.count_zero)
                        begin
                            state_next = bst_pkg::ST_SCAN;
                        end
                    end
                    bst_pkg::OP_CONTINUE:
                    begin
                        cmd.step_set = 1'b1;
                        kind_next    = bst_pkg::RES_FLAG;
                        if (!status.count_zero)
                        begin
                            state_next = bst_pkg::ST_ARM;
                        end
                    end
                    bst_pkg::OP_STEP:
                    begin
                        cmd.step_clr = 1'b1;
                        kind_next    = bst_pkg::RES_FLAG;
                    end
                    bst_pkg::OP_TRACE:
                    begin
                        if (status.stepping)
                        begin
                            // swallow the event and disarm
                            cmd.step_clr = 1'b1;
                            kind_next    = bst_pkg::RES_SWALLOW;
                        end
                        else
                        begin
                            kind_next = bst_pkg::RES_TRAP_MISS;
                            if (!status.count_zero)
                            begin
                                state_next = bst_pkg::ST_SCAN;
                            end
                        end
                    end
                    default:
                    begin
                        state_next = bst_pkg::ST_IDLE;
                    end
                endcase
            end
            bst_pkg::ST_SCAN:
            begin
                if (status.match)
                begin
                    cmd.capture = 1'b1;
                    if (status.op == bst_pkg::OP_REMOVE)
                    begin
                        // fetch the last entry to fill the hole
                        cmd.idx_tail = 1'b1;
                        kind_next    = bst_pkg::RES_REM_HIT;
                        state_next   = bst_pkg::ST_MOVE;
                    end
                    else
                    begin
                        kind_next  = bst_pkg::RES_TRAP_HIT;
                        state_next = bst_pkg::ST_EMIT;
                    end
                end
                else if (status.at_tail)
                begin
                    state_next = bst_pkg::ST_EMIT;
                end
                else
                begin
                    cmd.idx_inc = 1'b1;
                end
            end
            bst_pkg::ST_MOVE:
            begin
                cmd.move_write = 1'b1;
                cmd.count_dec  = 1'b1;
                state_next     = bst_pkg::ST_EMIT;
            end
            bst_pkg::ST_ARM:
            begin
                cmd.res_kind = bst_pkg::RES_ARM;
                if (status.out_free)
                begin
                    cmd.emit = 1'b1;
                    if (status.at_tail)
                    begin
                        state_next = bst_pkg::ST_IDLE;
                    end
                    else
                    begin
                        cmd.idx_inc = 1'b1;
                    end
                end
            end
            bst_pkg::ST_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = bst_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = bst_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

>>> rtl/breakpoint_shadow_table.sv
// ============================================================================
// breakpoint_shadow_table - software breakpoint table with trap byte handling
// Tracks breakpoint addresses with their original bytes and issues the byte
// writes needed to insert, remove, hit and re-arm them.
// ============================================================================
// Input beats (s_*) carry one command; s_tuser holds the opcode. Result beats
// (m_*) carry one write request / status word each; m_tlast marks the final
// beat of a command. Continue gives one beat per table entry (a single beat
// on an empty table), every other command gives one beat, opcodes six and
// seven give none. One command is in flight at a time: s_tready is high
// only while idle. Insert, step, trace swallow and commands on an empty
// table go from dispatch straight to the result register; remove, trap and
// a non-swallowed trace scan the table from index 0 until a match or the
// last entry, and a remove hit then fills the hole with the last entry.
// Continue streams one beat per cycle while the output register is free.
// The scan reads one entry per cycle and is not held by the output.
// Reset empties the table and disarms stepping-over; table contents are not
// cleared, only the count. When m_tready is low the output register holds
// its beat and the controller waits; no beat is dropped.
// ============================================================================
module breakpoint_shadow_table (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [bst_pkg::IN_DATA_W-1:0]     s_tdata,  // address[31:0], memory_byte[39:32]
    input  logic [2:0]                        s_tuser,  // opcode[2:0]
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [bst_pkg::OUT_DATA_W-1:0]    m_tdata,  // write_valid[0], write_address[32:1],
                                                        // write_data[40:33], hit[41],
                                                        // resume_pc[73:42], enter_debugger[74],
                                                        // set_trap_flag[75], zero[79:76]
    output logic                              m_tlast
);

    bst_pkg::cmd_t    cmd;
    bst_pkg::status_t status;

    bst_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    bst_dp u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .cmd      (cmd),
        .status   (status),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule
